// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/odo_pkg.sv -----
// types, constants and helper functions of the odometry block
package odo_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CW = 36;         // cordic x, y, z width
  localparam int AW = 48;         // unreduced midpoint angle width
  localparam int NW = 44;         // divider numerator magnitude width
  localparam int DSW = 34;        // travel width
  localparam int YW = 22;         // yaw width
  localparam int MOD_STEPS = 14;  // quotient bits of the angle reduction

  localparam logic [31:0] TICK_ANGLE_RST = 32'd6588397;
  localparam logic [15:0] RADIUS_RST = 16'd2163;

  localparam logic signed [CW-1:0] PI_Q = 36'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q = 36'sd1686629713;
  localparam logic signed [CW-1:0] TWO_PI_Q = 36'sd6746518852;
  localparam logic signed [CW-1:0] GAIN_INV_Q = 36'sd652032874;
  localparam logic signed [CW-1:0] DEN_BIAS = 36'sd134217728;
  localparam logic [AW-1:0] TWO_PI_M = 48'd6746518852;

  // atan(2^-i) in 2^-30 rad
  localparam logic signed [CW-1:0] ATAN_TAB [32] = '{
    36'sd843314857, 36'sd497837829, 36'sd263043837, 36'sd133525159, 36'sd67021687,
    36'sd33543516, 36'sd16775851, 36'sd8388437, 36'sd4194283, 36'sd2097149,
    36'sd1048576, 36'sd524288, 36'sd262144, 36'sd131072, 36'sd65536, 36'sd32768,
    36'sd16384, 36'sd8192, 36'sd4096, 36'sd2048, 36'sd1024, 36'sd512, 36'sd256,
    36'sd128, 36'sd64, 36'sd32, 36'sd16, 36'sd8, 36'sd4, 36'sd2, 36'sd1, 36'sd0
  };

  typedef enum logic [0:0] {
    REG_TICK_ANGLE = 1'b0,
    REG_RADIUS     = 1'b1
  } cfg_reg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_CLEAR, OP_ENC, OP_TICK_L, OP_INC_L, OP_TICK_R, OP_INC_R,
    OP_ACC, OP_QNUM, OP_QDEN, OP_DSMUL, OP_DSRND, OP_ATAN_GO, OP_YAW, OP_MID,
    OP_ROT_GO, OP_XMUL, OP_XADD, OP_YMUL, OP_YADD, OP_DIV_GO, OP_DIV_PUT,
    OP_COMMIT, OP_EMIT
  } dp_op_t;

  typedef enum logic [1:0] {
    DIV_LIN, DIV_TURN, DIV_LEFT, DIV_RIGHT
  } div_sel_t;

  typedef struct packed {
    dp_op_t   op;
    div_sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic func;
    logic ms_zero;
    logic cordic_done;
    logic div_done;
  } status_t;

  typedef struct packed {
    logic               func;
    logic               encoder_valid;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic [15:0]        elapsed_ms;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
    logic signed [31:0] linear_speed;
    logic signed [31:0] turn_rate;
    logic signed [31:0] left_angle;
    logic signed [31:0] right_angle;
    logic signed [31:0] left_speed;
    logic signed [31:0] right_speed;
    logic               updated;
  } result_t;

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -64'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  // shift right, rounding to nearest with ties away from zero
  function automatic logic signed [63:0] rnd(logic signed [63:0] v, int sh);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

endpackage

// ----- rtl/core/odo_if.sv -----
// channel interfaces of the odometry block

interface odo_sample_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic               encoder_valid;
  logic signed [31:0] left_count;
  logic signed [31:0] right_count;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic [15:0]        elapsed_ms;
  modport source (output valid, func, encoder_valid, left_count, right_count,
                  quat_w, quat_x, quat_y, quat_z, elapsed_ms, input ready);
  modport sink (input valid, func, encoder_valid, left_count, right_count,
                quat_w, quat_x, quat_y, quat_z, elapsed_ms, output ready);
endinterface

interface odo_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] heading;
  logic signed [31:0] linear_speed;
  logic signed [31:0] turn_rate;
  logic signed [31:0] left_angle;
  logic signed [31:0] right_angle;
  logic signed [31:0] left_speed;
  logic signed [31:0] right_speed;
  logic               updated;
  modport source (output valid, pos_x, pos_y, heading, linear_speed, turn_rate,
                  left_angle, right_angle, left_speed, right_speed, updated,
                  input ready);
  modport sink (input valid, pos_x, pos_y, heading, linear_speed, turn_rate,
                left_angle, right_angle, left_speed, right_speed, updated,
                output ready);
endinterface

interface odo_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/odo_cordic.sv -----
// iterative cordic: atan2 by vectoring, cos/sin by rotation with angle reduction
module odo_cordic #(
  parameter int STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           vector_mode,
  input  logic signed [odo_pkg::CW-1:0]  x_in,
  input  logic signed [odo_pkg::CW-1:0]  y_in,
  input  logic signed [odo_pkg::AW-1:0]  a_in,
  output logic signed [odo_pkg::CW-1:0]  x_out,
  output logic signed [odo_pkg::CW-1:0]  y_out,
  output logic signed [odo_pkg::CW-1:0]  z_out,
  output logic                           done
);
  import odo_pkg::*;

  localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int KW = $clog2(MOD_STEPS);

  typedef enum logic [4:0] {
    P_IDLE = 5'b00001,
    P_MOD  = 5'b00010,
    P_WRAP = 5'b00100,
    P_HALF = 5'b01000,
    P_ITER = 5'b10000
  } phase_t;

  phase_t               phase;
  logic signed [CW-1:0] x, y, z;
  logic [AW-1:0]        rem;
  logic                 neg_a, flip, vmode;
  logic [IW-1:0]        step;
  logic [KW-1:0]        k;
  logic signed [CW-1:0] xs, ys, tab, zr;
  logic [AW-1:0]        sub_amt;
  logic                 sigma;

  always_comb begin
    xs = x >>> step;
    ys = y >>> step;
    tab = ATAN_TAB[5'(step)];
    sigma = vmode ? !y[CW-1] : z[CW-1];
    sub_amt = TWO_PI_M << k;
    zr = neg_a ? -$signed(CW'(rem)) : $signed(CW'(rem));
  end

  assign x_out = flip ? -x : x;
  assign y_out = flip ? -y : y;
  assign z_out = z;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        P_IDLE: begin
          if (start) begin
            vmode <= vector_mode;
            flip <= 1'b0;
            step <= '0;
            if (vector_mode) begin
              if (x_in == '0 && y_in == '0) begin
                x <= '0;
                y <= '0;
                z <= '0;
                done <= 1'b1;
              end else if (x_in < 0) begin
                z <= y_in[CW-1] ? -PI_Q : PI_Q;
                x <= -x_in;
                y <= -y_in;
                phase <= P_ITER;
              end else begin
                z <= '0;
                x <= x_in;
                y <= y_in;
                phase <= P_ITER;
              end
            end else begin
              rem <= a_in[AW-1] ? AW'(-a_in) : AW'(a_in);
              neg_a <= a_in[AW-1];
              k <= KW'(MOD_STEPS - 1);
              phase <= P_MOD;
            end
          end
        end
        P_MOD: begin
          // restoring reduction of the magnitude by 2 pi
          if (rem >= sub_amt) rem <= rem - sub_amt;
          if (k == '0) phase <= P_WRAP;
          else k <= k - 1'b1;
        end
        P_WRAP: begin
          if (zr > PI_Q) z <= zr - TWO_PI_Q;
          else if (zr < -PI_Q) z <= zr + TWO_PI_Q;
          else z <= zr;
          phase <= P_HALF;
        end
        P_HALF: begin
          if (z > HALF_PI_Q) begin
            z <= z - PI_Q;
            flip <= 1'b1;
          end else if (z < -HALF_PI_Q) begin
            z <= z + PI_Q;
            flip <= 1'b1;
          end
          x <= GAIN_INV_Q;
          y <= '0;
          phase <= P_ITER;
        end
        P_ITER: begin
          if (sigma) begin
            x <= x + ys;
            y <= y - xs;
            z <= z + tab;
          end else begin
            x <= x - ys;
            y <= y + xs;
            z <= z - tab;
          end
          if (step == IW'(STEPS - 1)) begin
            phase <= P_IDLE;
            done <= 1'b1;
          end else begin
            step <= step + 1'b1;
          end
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/odo_div.sv -----
// restoring divider, one quotient bit a cycle, rounded and saturated result
module odo_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic signed [odo_pkg::NW-1:0]  num,
  input  logic [15:0]                    den,
  output logic signed [31:0]             q,
  output logic                           done
);
  import odo_pkg::*;

  localparam int CNTW = $clog2(NW);

  logic [NW-1:0]    sreg;
  logic [15:0]      rem;
  logic             neg, busy, fits;
  logic [CNTW-1:0]  cnt;
  logic [16:0]      rem_sh;
  logic signed [NW:0] qs;

  always_comb begin
    rem_sh = {rem, sreg[NW-1]};
    fits = rem_sh >= {1'b0, den};
    qs = neg ? -$signed({1'b0, sreg}) : $signed({1'b0, sreg});
    q = sat32(64'(qs));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // half the divisor is added first so the quotient comes out rounded
        neg <= num[NW-1];
        sreg <= (num[NW-1] ? NW'(-num) : NW'(num)) + NW'(den >> 1);
        rem <= '0;
        cnt <= CNTW'(NW - 1);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? 16'(rem_sh - {1'b0, den}) : rem_sh[15:0];
        sreg <= {sreg[NW-2:0], fits};
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/odo_ctrl.sv -----
// sequencing state machine of the odometry block
module odo_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_ready,
  output logic             result_valid,
  input  logic             result_ready,
  input  odo_pkg::status_t status,
  output odo_pkg::cmd_t    cmd
);
  import odo_pkg::*;

  localparam int SW = 26;

  typedef enum logic [SW-1:0] {
    S_IDLE    = 26'd1 << 0,
    S_DECIDE  = 26'd1 << 1,
    S_TICK_L  = 26'd1 << 2,
    S_INC_L   = 26'd1 << 3,
    S_TICK_R  = 26'd1 << 4,
    S_INC_R   = 26'd1 << 5,
    S_ACC     = 26'd1 << 6,
    S_QNUM    = 26'd1 << 7,
    S_QDEN    = 26'd1 << 8,
    S_DSMUL   = 26'd1 << 9,
    S_DSRND   = 26'd1 << 10,
    S_ATAN    = 26'd1 << 11,
    S_ATAN_W  = 26'd1 << 12,
    S_YAW     = 26'd1 << 13,
    S_MID     = 26'd1 << 14,
    S_ROT     = 26'd1 << 15,
    S_ROT_W   = 26'd1 << 16,
    S_XMUL    = 26'd1 << 17,
    S_XADD    = 26'd1 << 18,
    S_YMUL    = 26'd1 << 19,
    S_YADD    = 26'd1 << 20,
    S_DIV     = 26'd1 << 21,
    S_DIV_W   = 26'd1 << 22,
    S_DIV_PUT = 26'd1 << 23,
    S_COMMIT  = 26'd1 << 24,
    S_EMIT    = 26'd1 << 25
  } state_t;

  state_t   state, state_next;
  div_sel_t div_idx, div_idx_next;
  logic     result_valid_next;

  assign sample_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    div_idx_next = div_idx;
    result_valid_next = result_valid && !result_ready;
    cmd.op = OP_NONE;
    cmd.sel = div_idx;
    case (state)
      S_IDLE: begin
        if (sample_valid) begin
          cmd.op = OP_LOAD;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.op = status.func ? OP_CLEAR : OP_ENC;
        state_next = status.func ? S_EMIT : S_TICK_L;
      end
      S_TICK_L: begin cmd.op = OP_TICK_L; state_next = S_INC_L; end
      S_INC_L:  begin cmd.op = OP_INC_L;  state_next = S_TICK_R; end
      S_TICK_R: begin cmd.op = OP_TICK_R; state_next = S_INC_R; end
      S_INC_R:  begin cmd.op = OP_INC_R;  state_next = S_ACC; end
      S_ACC: begin
        cmd.op = OP_ACC;
        state_next = status.ms_zero ? S_EMIT : S_QNUM;
      end
      S_QNUM:   begin cmd.op = OP_QNUM;   state_next = S_QDEN; end
      S_QDEN:   begin cmd.op = OP_QDEN;   state_next = S_DSMUL; end
      S_DSMUL:  begin cmd.op = OP_DSMUL;  state_next = S_DSRND; end
      S_DSRND:  begin cmd.op = OP_DSRND;  state_next = S_ATAN; end
      S_ATAN:   begin cmd.op = OP_ATAN_GO; state_next = S_ATAN_W; end
      S_ATAN_W: begin
        if (status.cordic_done) state_next = S_YAW;
      end
      S_YAW:    begin cmd.op = OP_YAW;    state_next = S_MID; end
      S_MID:    begin cmd.op = OP_MID;    state_next = S_ROT; end
      S_ROT:    begin cmd.op = OP_ROT_GO; state_next = S_ROT_W; end
      S_ROT_W: begin
        if (status.cordic_done) state_next = S_XMUL;
      end
      S_XMUL:   begin cmd.op = OP_XMUL;   state_next = S_XADD; end
      S_XADD:   begin cmd.op = OP_XADD;   state_next = S_YMUL; end
      S_YMUL:   begin cmd.op = OP_YMUL;   state_next = S_YADD; end
      S_YADD: begin
        cmd.op = OP_YADD;
        div_idx_next = DIV_LIN;
        state_next = S_DIV;
      end
      S_DIV:    begin cmd.op = OP_DIV_GO; state_next = S_DIV_W; end
      S_DIV_W: begin
        if (status.div_done) state_next = S_DIV_PUT;
      end
      S_DIV_PUT: begin
        cmd.op = OP_DIV_PUT;
        if (div_idx == DIV_RIGHT) begin
          state_next = S_COMMIT;
        end else begin
          div_idx_next = div_sel_t'(div_idx + 1'b1);
          state_next = S_DIV;
        end
      end
      S_COMMIT: begin cmd.op = OP_COMMIT; state_next = S_EMIT; end
      S_EMIT: begin
        // wait for the output register to be free
        if (!result_valid || result_ready) begin
          cmd.op = OP_EMIT;
          result_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      div_idx <= DIV_LIN;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      div_idx <= div_idx_next;
      result_valid <= result_valid_next;
    end
  end

endmodule

// ----- rtl/core/odo_dp.sv -----
// odometry datapath: state, configuration, multipliers, cordic and divider
module odo_dp #(
  parameter int CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  odo_pkg::cmd_t     cmd,
  output odo_pkg::status_t  status,
  input  logic              cfg_we,
  input  odo_pkg::cfg_reg_t cfg_index,
  input  logic [31:0]       cfg_data,
  input  odo_pkg::sample_t  sample_in,
  output odo_pkg::result_t  result_out
);
  import odo_pkg::*;

  // configuration
  logic [31:0] tick_angle;
  logic [15:0] radius;

  // latched sample
  sample_t smp;

  // persistent state
  logic               relatch;
  logic [31:0]        prev_l, prev_r, delta_l, delta_r;
  logic signed [31:0] angle_l, angle_r, wspeed_l, wspeed_r;
  logic signed [31:0] pos_x, pos_y, heading, lin_speed, turn_rate;
  logic signed [YW-1:0] prev_yaw;

  // per-item working registers
  logic                  acc, updated;
  logic signed [63:0]    prod;
  logic signed [31:0]    il, ir;
  logic signed [CW-1:0]  qnum, qden;
  logic signed [DSW-1:0] ds;
  logic signed [YW-1:0]  yaw;
  logic signed [YW:0]    dth;
  logic signed [AW-1:0]  mid;

  // units
  logic                 cordic_start, cordic_done;
  logic signed [CW-1:0] cx, cy, cz;
  logic                 div_start, div_done;
  logic signed [NW-1:0] div_num;
  logic signed [31:0]   div_q;
  logic signed [63:0]   div_src;
  logic signed [YW:0]   dth_c;
  logic signed [32:0]   tick_s;
  logic signed [16:0]   radius_s;

  assign cordic_start = (cmd.op == OP_ATAN_GO) || (cmd.op == OP_ROT_GO);
  assign div_start = (cmd.op == OP_DIV_GO);
  assign tick_s = $signed({1'b0, tick_angle});
  assign radius_s = $signed({1'b0, radius});
  assign dth_c = (YW+1)'(yaw) - (YW+1)'(prev_yaw);

  always_comb begin
    case (cmd.sel)
      DIV_LIN:  div_src = 64'(ds);
      DIV_TURN: div_src = 64'(dth);
      DIV_LEFT: div_src = 64'(il);
      default:  div_src = 64'(ir);
    endcase
    div_num = NW'(div_src * 64'sd1000);
  end

  assign status.func = smp.func;
  assign status.ms_zero = (smp.elapsed_ms == '0);
  assign status.cordic_done = cordic_done;
  assign status.div_done = div_done;

  odo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk         (clk),
    .rst         (rst),
    .start       (cordic_start),
    .vector_mode (cmd.op == OP_ATAN_GO),
    .x_in        (qden),
    .y_in        (qnum),
    .a_in        (mid),
    .x_out       (cx),
    .y_out       (cy),
    .z_out       (cz),
    .done        (cordic_done)
  );

  odo_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (smp.elapsed_ms),
    .q     (div_q),
    .done  (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_angle <= TICK_ANGLE_RST;
      radius <= RADIUS_RST;
      relatch <= 1'b1;
      prev_l <= '0;
      prev_r <= '0;
      delta_l <= '0;
      delta_r <= '0;
      angle_l <= '0;
      angle_r <= '0;
      wspeed_l <= '0;
      wspeed_r <= '0;
      pos_x <= '0;
      pos_y <= '0;
      heading <= '0;
      lin_speed <= '0;
      turn_rate <= '0;
      prev_yaw <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TICK_ANGLE: tick_angle <= cfg_data;
          REG_RADIUS:     radius <= cfg_data[15:0];
          default: ;
        endcase
      end
      case (cmd.op)
        OP_LOAD: begin
          smp <= sample_in;
          updated <= 1'b0;
        end
        OP_CLEAR: begin
          relatch <= 1'b1;
          pos_x <= '0;
          pos_y <= '0;
          heading <= '0;
          lin_speed <= '0;
          turn_rate <= '0;
        end
        OP_ENC: begin
          acc <= 1'b0;
          if (smp.encoder_valid) begin
            if (relatch) begin
              delta_l <= '0;
              delta_r <= '0;
              angle_l <= '0;
              angle_r <= '0;
              wspeed_l <= '0;
              wspeed_r <= '0;
            end else begin
              delta_l <= smp.left_count - prev_l;
              delta_r <= smp.right_count - prev_r;
              acc <= 1'b1;
            end
            prev_l <= smp.left_count;
            prev_r <= smp.right_count;
            relatch <= 1'b0;
          end
        end
        OP_TICK_L: prod <= tick_s * $signed(delta_l);
        OP_INC_L:  il <= sat32(rnd(prod, 16));
        OP_TICK_R: prod <= tick_s * $signed(delta_r);
        OP_INC_R:  ir <= sat32(rnd(prod, 16));
        OP_ACC: begin
          if (acc) begin
            angle_l <= sat32(64'(angle_l) + 64'(il));
            angle_r <= sat32(64'(angle_r) + 64'(ir));
          end
        end
        OP_QNUM: qnum <= CW'(smp.quat_x) * CW'(smp.quat_y)
                         + CW'(smp.quat_w) * CW'(smp.quat_z);
        OP_QDEN: qden <= DEN_BIAS - CW'(smp.quat_y) * CW'(smp.quat_y)
                         - CW'(smp.quat_z) * CW'(smp.quat_z);
        OP_DSMUL: prod <= radius_s * (DSW'(il) + DSW'(ir));
        OP_DSRND: ds <= DSW'(rnd(prod, 17));
        OP_YAW:   yaw <= YW'(rnd(64'(cz), 14));
        OP_MID: begin
          dth <= dth_c;
          // midpoint heading in 2^-30 rad
          mid <= (AW'(heading) <<< 14) + (AW'(dth_c) <<< 13);
        end
        OP_XMUL: prod <= ds * $signed(cx[31:0]);
        OP_XADD: pos_x <= sat32(64'(pos_x) + rnd(prod, 30));
        OP_YMUL: prod <= ds * $signed(cy[31:0]);
        OP_YADD: pos_y <= sat32(64'(pos_y) + rnd(prod, 30));
        OP_DIV_PUT: begin
          case (cmd.sel)
            DIV_LIN:  lin_speed <= div_q;
            DIV_TURN: turn_rate <= div_q;
            DIV_LEFT: wspeed_l <= div_q;
            default:  wspeed_r <= div_q;
          endcase
        end
        OP_COMMIT: begin
          heading <= sat32(64'(heading) + 64'(dth));
          prev_yaw <= yaw;
          updated <= 1'b1;
        end
        OP_EMIT: begin
          result_out.pos_x <= pos_x;
          result_out.pos_y <= pos_y;
          result_out.heading <= heading;
          result_out.linear_speed <= lin_speed;
          result_out.turn_rate <= turn_rate;
          result_out.left_angle <= angle_l;
          result_out.right_angle <= angle_r;
          result_out.left_speed <= wspeed_l;
          result_out.right_speed <= wspeed_r;
          result_out.updated <= updated;
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/differential_drive_odometry_top.sv -----
// top level of the differential-drive odometry block
// channels: sample (sink) takes one sample or reset item per transfer;
//   result (source) gives one pose/speed item for each accepted item;
//   cfg (sink) writes tick_angle (index 0) or the wheel radius (index 1), always ready.
// one item is worked on at a time; sample.ready is high only while idle.
// the time from accept to result valid of a full pose step is set by the two
//   cordic passes, the angle reduction and four serial divisions (44 quotient
//   bits plus handover).
// the next sample is taken in the cycle after the result is loaded.
// the result sits in an output register, so a new sample is taken while a
//   finished result still waits; a stalled receiver holds the result and
//   only delays the end of the following item.
// reset (rst, synchronous) clears the pose, speeds, wheel angles, counts and
//   yaw memory, loads the default registers and arms the count re-latch.
module differential_drive_odometry_top #(
  parameter int CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
  input logic          clk,
  input logic          rst,
  odo_sample_if.sink   sample,
  odo_result_if.source result,
  odo_cfg_if.sink      cfg
);
  import odo_pkg::*;

  cmd_t    cmd;
  status_t status;
  sample_t sample_in;
  result_t result_out;

  assign cfg.ready = 1'b1;

  assign sample_in.func = sample.func;
  assign sample_in.encoder_valid = sample.encoder_valid;
  assign sample_in.left_count = sample.left_count;
  assign sample_in.right_count = sample.right_count;
  assign sample_in.quat_w = sample.quat_w;
  assign sample_in.quat_x = sample.quat_x;
  assign sample_in.quat_y = sample.quat_y;
  assign sample_in.quat_z = sample.quat_z;
  assign sample_in.elapsed_ms = sample.elapsed_ms;

  assign result.pos_x = result_out.pos_x;
  assign result.pos_y = result_out.pos_y;
  assign result.heading = result_out.heading;
  assign result.linear_speed = result_out.linear_speed;
  assign result.turn_rate = result_out.turn_rate;
  assign result.left_angle = result_out.left_angle;
  assign result.right_angle = result_out.right_angle;
  assign result.left_speed = result_out.left_speed;
  assign result.right_speed = result_out.right_speed;
  assign result.updated = result_out.updated;

  odo_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample.valid),
    .sample_ready (sample.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .status       (status),
    .cmd          (cmd)
  );

  odo_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_we     (cfg.valid),
    .cfg_index  (cfg_reg_t'(cfg.index)),
    .cfg_data   (cfg.data),
    .sample_in  (sample_in),
    .result_out (result_out)
  );

endmodule

// ----- rtl/core/odo_checker.sv -----
// port-level assertions of the odometry block and their bind
`include "assert_macros.svh"

module odo_checker (
  input logic        clk,
  input logic        rst,
  input logic        sample_valid,
  input logic        sample_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [31:0] pos_x,
  input logic        updated
);

  // one item at a time: no transfer right after a transfer
  `ASSERT_NEXT(a_one_item, clk, rst, sample_valid && sample_ready, !sample_ready)

  `ASSERT_IMPLIES(a_quiet_after_rst, clk, rst, $past(rst), !result_valid)

  // a result never appears in the cycle straight after its sample transfer
  `ASSERT_IMPLIES(a_result_latency, clk, rst, $rose(result_valid), !$past(sample_valid && sample_ready))

  `ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(pos_x) && $stable(updated))

endmodule

bind differential_drive_odometry_top odo_checker u_odo_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample.valid),
  .sample_ready (sample.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .pos_x        (result.pos_x),
  .updated      (result.updated)
);
